[rtl/nzef_pkg.sv]
// ----------------------------------------------------------------------------
// nzef_pkg
// Shared types, widths and register codes of the nonzero extent finder.
// ----------------------------------------------------------------------------
package nzef_pkg;

    // Offset counter width; offsets, starts and lengths wrap at this size.
    localparam int ADDR_BITS  = 40;
    // Width of the extent fields and of the configuration registers.
    localparam int FIELD_BITS = 40;
    localparam int BYTE_BITS  = 8;
    localparam int REG_IDX_BITS = 1;

    typedef logic [ADDR_BITS-1:0]    addr_t;
    typedef logic [FIELD_BITS-1:0]   field_t;
    typedef logic [BYTE_BITS-1:0]    byte_t;
    typedef logic [REG_IDX_BITS-1:0] reg_idx_t;

    // Register indexes of the configuration port.
    localparam reg_idx_t REG_HEADER_BYTES = 1'b0;
    localparam reg_idx_t REG_CHUNK_BYTES  = 1'b1;

    localparam field_t HEADER_BYTES_RESET = FIELD_BITS'(64'd115343360);
    localparam field_t CHUNK_BYTES_RESET  = FIELD_BITS'(64'd34603008);

    // Result of one step of the extent tracker.
    typedef struct packed {
        logic   produce;
        field_t extent_start;
        field_t extent_length;
        logic   extent_valid;
        logic   end_of_image;
        logic   size_overflow;
    } nzef_result_t;

    // Map an offset-width value onto a field: truncate or zero-extend.
    function automatic field_t addr_to_field(input addr_t a);
        logic [63:0] wide;
        wide = 64'(a);
        return wide[FIELD_BITS-1:0];
    endfunction

endpackage

[rtl/nzef_if.sv]
// ----------------------------------------------------------------------------
// nzef interfaces
// Image byte channel, extent result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface nzef_in_if;
    import nzef_pkg::*;

    logic  valid;
    logic  ready;
    byte_t data_byte;
    logic  last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface nzef_out_if;
    import nzef_pkg::*;

    logic   valid;
    logic   ready;
    field_t extent_start;
    field_t extent_length;
    logic   extent_valid;
    logic   end_of_image;
    logic   size_overflow;

    modport source (output valid, output extent_start, output extent_length,
                    output extent_valid, output end_of_image, output size_overflow,
                    input ready);
    modport sink   (input valid, input extent_start, input extent_length,
                    input extent_valid, input end_of_image, input size_overflow,
                    output ready);
endinterface

interface nzef_cfg_if;
    import nzef_pkg::*;

    logic     valid;
    logic     ready;
    reg_idx_t reg_index;
    field_t   write_data;

    modport source (output valid, output reg_index, output write_data, input ready);
    modport sink   (input valid, input reg_index, input write_data, output ready);
endinterface

[rtl/nzef_tracker.sv]
// ----------------------------------------------------------------------------
// nzef_tracker
// Extent tracking state and the per-byte update of offset, chunk and run.
// ----------------------------------------------------------------------------
module nzef_tracker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  nzef_pkg::byte_t       data_byte,
    input  logic                  last_byte,
    input  nzef_pkg::field_t      header_limit,
    input  nzef_pkg::field_t      chunk_limit,
    output nzef_pkg::nzef_result_t result
);
    import nzef_pkg::*;

    addr_t  byte_offset_reg, byte_offset_next;
    field_t chunk_count_reg, chunk_count_next;
    logic   chunk_has_data_reg, chunk_has_data_next;
    logic   run_open_reg, run_open_next;
    addr_t  run_start_reg, run_start_next;
    addr_t  run_length_reg, run_length_next;
    logic   overflow_seen_reg, overflow_seen_next;

    addr_t  offset_inc;
    field_t count_inc;
    logic   in_header;
    logic   has_data;
    logic   chunk_end;
    logic   emit;
    addr_t  emit_start;
    addr_t  emit_length;

    always_comb
    begin
        offset_inc = byte_offset_reg + 1'b1;
        count_inc  = chunk_count_reg + 1'b1;
        in_header  = !overflow_seen_reg && (64'(byte_offset_reg) < 64'(header_limit));
        has_data   = chunk_has_data_reg || (data_byte != '0);
        chunk_end  = (count_inc >= chunk_limit) || last_byte;

        byte_offset_next    = offset_inc;
        overflow_seen_next  = overflow_seen_reg || (offset_inc == '0);
        chunk_count_next    = chunk_count_reg;
        chunk_has_data_next = chunk_has_data_reg;
        run_open_next       = run_open_reg;
        run_start_next      = run_start_reg;
        run_length_next     = run_length_reg;
        emit                = 1'b0;
        emit_start          = '0;
        emit_length         = '0;

        if (in_header)
        begin
            run_length_next = run_length_reg + 1'b1;
        end
        else if (chunk_end)
        begin
            // Close the chunk: extend or open the run, or report the open run.
            chunk_count_next    = '0;
            chunk_has_data_next = 1'b0;
            if (has_data)
            begin
                if (run_open_reg)
                begin
                    run_length_next = run_length_reg + ADDR_BITS'(count_inc);
                end
                else
                begin
                    run_start_next  = offset_inc - ADDR_BITS'(count_inc);
                    run_length_next = ADDR_BITS'(count_inc);
                    run_open_next   = 1'b1;
                end
            end
            else if (run_open_reg)
            begin
                emit          = 1'b1;
                emit_start    = run_start_reg;
                emit_length   = run_length_reg;
                run_open_next = 1'b0;
            end
        end
        else
        begin
            chunk_count_next    = count_inc;
            chunk_has_data_next = has_data;
        end

        if (last_byte && run_open_next && !emit)
        begin
            emit        = 1'b1;
            emit_start  = run_start_next;
            emit_length = run_length_next;
        end

        result.produce       = emit || last_byte;
        result.extent_start  = addr_to_field(emit_start);
        result.extent_length = addr_to_field(emit_length);
        result.extent_valid  = emit;
        result.end_of_image  = last_byte;
        result.size_overflow = overflow_seen_next;

        // Return to the start-of-image state after the final byte.
        if (last_byte)
        begin
            byte_offset_next    = '0;
            chunk_count_next    = '0;
            chunk_has_data_next = 1'b0;
            run_open_next       = 1'b1;
            run_start_next      = '0;
            run_length_next     = '0;
            overflow_seen_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_offset_reg    <= '0;
            chunk_count_reg    <= '0;
            chunk_has_data_reg <= 1'b0;
            run_open_reg       <= 1'b1;
            run_start_reg      <= '0;
            run_length_reg     <= '0;
            overflow_seen_reg  <= 1'b0;
        end
        else if (step)
        begin
            byte_offset_reg    <= byte_offset_next;
            chunk_count_reg    <= chunk_count_next;
            chunk_has_data_reg <= chunk_has_data_next;
            run_open_reg       <= run_open_next;
            run_start_reg      <= run_start_next;
            run_length_reg     <= run_length_next;
            overflow_seen_reg  <= overflow_seen_next;
        end
    end

endmodule

[rtl/nzef_top.sv]
// ----------------------------------------------------------------------------
// nonzero_extent_finder_top
// Finds the extents of an image that hold nonzero data, one byte per item.
// ----------------------------------------------------------------------------
// The block takes an image one byte per item on the image channel, with
// last_byte set on the final byte, and reports extents on the extent channel.
// The first header_bytes bytes always form an extent at offset 0; the rest is
// tested in chunks of chunk_bytes, touching nonzero chunks are merged, and an
// all-zero chunk closes the open extent and reports it. The final byte always
// gives a result with end_of_image set (extent_valid clear for a bare end
// mark). Throughput is one item per cycle: each byte needs only three
// increments, one 40-bit add, one 40-bit subtract and a few compares, done
// in a single step between the input register and the result register. An
// accepted item passes the input register and then the result register on
// its way to being offered. The image channel stalls only while a result
// waits in the output register and the extent channel is not ready.
// Registers are written through the cfg channel, which is always ready; a
// value of zero in either register acts as one. Write them only between
// images.
// ----------------------------------------------------------------------------
module nonzero_extent_finder_top (
    input  logic       clk,
    input  logic       rst_n,
    nzef_in_if.sink    image,
    nzef_out_if.source extent,
    nzef_cfg_if.sink   cfg
);
    import nzef_pkg::*;

    // Configuration, held already clamped to at least one.
    field_t header_limit_reg;
    field_t chunk_limit_reg;
    field_t cfg_value;

    // Input register.
    logic   in_valid_reg;
    byte_t  in_byte_reg;
    logic   in_last_reg;

    // Result register.
    logic         out_valid_reg;
    nzef_result_t out_reg;

    nzef_result_t step_result;
    logic         advance;

    // Advance the held byte whenever the result slot is free or being drained.
    assign advance     = in_valid_reg && (!out_valid_reg || extent.ready);
    assign image.ready = !in_valid_reg || advance;
    assign cfg.ready   = 1'b1;
    assign cfg_value   = (cfg.write_data == '0) ? FIELD_BITS'(1) : cfg.write_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_limit_reg <= HEADER_BYTES_RESET;
            chunk_limit_reg  <= CHUNK_BYTES_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.reg_index)
                REG_HEADER_BYTES: header_limit_reg <= cfg_value;
                REG_CHUNK_BYTES:  chunk_limit_reg  <= cfg_value;
                default:          ;
            endcase
        end
    end

    // Hold the byte until the tracker consumes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (image.ready)
        begin
            in_valid_reg <= image.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (image.valid && image.ready)
        begin
            in_byte_reg <= image.data_byte;
            in_last_reg <= image.last_byte;
        end
    end

    nzef_tracker u_tracker (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .data_byte    (in_byte_reg),
        .last_byte    (in_last_reg),
        .header_limit (header_limit_reg),
        .chunk_limit  (chunk_limit_reg),
        .result       (step_result)
    );

    // Load a new result on advance; drop the offered one once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= step_result.produce;
        end
        else if (extent.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && step_result.produce)
        begin
            out_reg <= step_result;
        end
    end

    assign extent.valid         = out_valid_reg;
    assign extent.extent_start  = out_reg.extent_start;
    assign extent.extent_length = out_reg.extent_length;
    assign extent.extent_valid  = out_reg.extent_valid;
    assign extent.end_of_image  = out_reg.end_of_image;
    assign extent.size_overflow = out_reg.size_overflow;

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nonzero extent finder. Images are streamed in
// one byte per item under several header and chunk sizes, each extent result
// is checked field by field against a cycle-free model of the tracker, and
// both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import nzef_pkg::*;

    // Clock half period, bench timeout and the settle time after a drain.
    localparam int          HALF_PERIOD   = 6;
    localparam longint      RUN_LIMIT     = 64'd15_000_000;
    localparam int          SETTLE_CYCLES = 6;
    // Stop the random part once this many image bytes have gone in.
    localparam int          TARGET_ITEMS  = 2000;
    localparam int          PHASE_ITEMS   = 220;
    // Longest idle stretch either side may draw for one item.
    localparam int          MAX_WAIT      = 18;
    // Keep the log short if the block is badly broken.
    localparam int unsigned REPORT_CAP    = 40;
    localparam field_t      FIELD_MAX     = '1;

    // Header and chunk sizes for the opening random phases; the extremes
    // (zero acting as one, and all ones) sit among them.
    localparam field_t PRESET_HEADER [0:7] =
        '{field_t'(1), field_t'(2), field_t'(5), FIELD_MAX,
          field_t'(3), FIELD_MAX, field_t'(0), field_t'(8)};
    localparam field_t PRESET_CHUNK [0:7] =
        '{field_t'(1), field_t'(3), field_t'(4), field_t'(2),
          FIELD_MAX, FIELD_MAX, field_t'(6), field_t'(0)};

    // One expected or observed result on the extent channel.
    typedef struct packed {
        field_t start;
        field_t length;
        logic   has_extent;
        logic   image_end;
        logic   overflow;
    } extent_rec_t;

    // Shape of a stretch of image content.
    typedef enum int {
        FILL_ZERO,
        FILL_DENSE,
        FILL_SPARSE
    } fill_kind_t;

    // ------------------------------------------------------------------------
    // Extent ledger: tracks the image as the block should, queues the extent
    // each accepted byte ought to produce and checks the results that emerge.
    // ------------------------------------------------------------------------
    class extent_ledger;
        field_t      header_len;
        field_t      chunk_len;
        addr_t       offset;
        field_t      chunk_fill;
        bit          chunk_dirty;
        bit          run_open;
        addr_t       run_start;
        addr_t       run_len;
        bit          wrapped;
        extent_rec_t awaited_extents [$];
        int unsigned failures;

        function new();
            header_len = HEADER_BYTES_RESET;
            chunk_len  = CHUNK_BYTES_RESET;
            failures   = 0;
            clear_image();
        endfunction

        function void clear_image();
            offset      = '0;
            chunk_fill  = '0;
            chunk_dirty = 1'b0;
            run_open    = 1'b1;     // header extent is open from the start
            run_start   = '0;
            run_len     = '0;
            wrapped     = 1'b0;
        endfunction

        function void set_register(reg_idx_t idx, field_t value);
            if (idx == REG_HEADER_BYTES)
                header_len = value;
            else
                chunk_len = value;
        endfunction

        // Advance the tracker by one accepted image byte.
        function void note_byte(byte_t data, logic last);
            addr_t       pos;
            bit          was_wrapped;
            field_t      hdr;
            field_t      chk;
            extent_rec_t rec;
            pos         = offset;
            was_wrapped = wrapped;
            hdr         = (header_len == '0) ? field_t'(1) : header_len;
            chk         = (chunk_len == '0) ? field_t'(1) : chunk_len;
            rec         = '0;

            offset = pos + 1'b1;
            if (offset == '0)
                wrapped = 1'b1;

            if (!was_wrapped && pos < hdr) begin
                run_len = run_len + 1'b1;
            end
            else begin
                chunk_fill = chunk_fill + 1'b1;
                if (data != '0)
                    chunk_dirty = 1'b1;
                if (chunk_fill >= chk || last) begin
                    if (chunk_dirty) begin
                        if (run_open) begin
                            run_len = run_len + chunk_fill;
                        end
                        else begin
                            run_start = pos + 1'b1 - chunk_fill;
                            run_len   = chunk_fill;
                            run_open  = 1'b1;
                        end
                    end
                    else if (run_open) begin
                        rec.has_extent = 1'b1;
                        rec.start      = addr_to_field(run_start);
                        rec.length     = addr_to_field(run_len);
                        run_open       = 1'b0;
                    end
                    chunk_fill  = '0;
                    chunk_dirty = 1'b0;
                end
            end

            if (last && run_open && !rec.has_extent) begin
                rec.has_extent = 1'b1;
                rec.start      = addr_to_field(run_start);
                rec.length     = addr_to_field(run_len);
            end

            if (rec.has_extent || last) begin
                rec.image_end = last;
                rec.overflow  = wrapped;
                awaited_extents.insert(awaited_extents.size(), rec);
            end
            if (last)
                clear_image();
        endfunction

        function void compare(string what, field_t want, field_t got);
            if (want !== got) begin
                failures++;
                if (failures <= REPORT_CAP)
                    $display("%0t: %s mismatch, expected %0h, actual %0h",
                             $time, what, want, got);
            end
        endfunction

        // Check one accepted result against the oldest expectation.
        function void check_result(extent_rec_t got);
            extent_rec_t want;
            if (awaited_extents.size() == 0) begin
                failures++;
                if (failures <= REPORT_CAP)
                    $display("%0t: unexpected extent result, expected none, actual %h",
                             $time, got);
                return;
            end
            want = awaited_extents.pop_front();
            compare("extent_start",  want.start,              got.start);
            compare("extent_length", want.length,             got.length);
            compare("extent_valid",  field_t'(want.has_extent), field_t'(got.has_extent));
            compare("end_of_image",  field_t'(want.image_end),  field_t'(got.image_end));
            compare("size_overflow", field_t'(want.overflow),   field_t'(got.overflow));
        endfunction

        function int unsigned pending();
            return awaited_extents.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    nzef_in_if  image_ch();
    nzef_out_if extent_ch();
    nzef_cfg_if cfg_ch();

    nonzero_extent_finder_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .image  (image_ch),
        .extent (extent_ch),
        .cfg    (cfg_ch)
    );

    extent_ledger ledger = new();

    int unsigned items_sent = 0;

    // Idle patterns of the two sides: a stretch of items either runs flat out
    // or draws a fresh random wait, bounded by MAX_WAIT, for every item.
    int send_left  = 0;
    bit send_quiet = 1'b0;
    int take_left  = 0;
    bit take_quiet = 1'b0;

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Draw the wait before the next item; start a new stretch when one runs out.
    function automatic int draw_wait(inout int left, inout bit quiet);
        if (left == 0) begin
            left  = $urandom_range(8, 60);
            quiet = ($urandom_range(0, 2) == 0);
        end
        left--;
        return quiet ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // Offer one image byte and hold it until the block takes it. Keep valid
    // high across back-to-back items so it never drops and rises in one step.
    task automatic push_byte(byte_t data, logic last);
        int gap;
        gap = draw_wait(send_left, send_quiet);
        if (gap > 0) begin
            image_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        image_ch.valid     <= 1'b1;
        image_ch.data_byte <= data;
        image_ch.last_byte <= last;
        do @(posedge clk); while (!image_ch.ready);
        ledger.note_byte(data, last);
        items_sent++;
    endtask

    // Hold the sender until every awaited extent has arrived, then let the
    // pipeline settle so the block is idle.
    task automatic drain_results();
        image_ch.valid <= 1'b0;
        while (ledger.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both size registers; only called while the block is idle.
    task automatic set_sizes(field_t header_len, field_t chunk_len);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.reg_index  <= REG_HEADER_BYTES;
        cfg_ch.write_data <= header_len;
        do @(posedge clk); while (!cfg_ch.ready);
        ledger.set_register(REG_HEADER_BYTES, header_len);
        cfg_ch.reg_index  <= REG_CHUNK_BYTES;
        cfg_ch.write_data <= chunk_len;
        do @(posedge clk); while (!cfg_ch.ready);
        ledger.set_register(REG_CHUNK_BYTES, chunk_len);
        cfg_ch.valid <= 1'b0;
    endtask

    // Stream one image of random length built from stretches of zero bytes,
    // solid nonzero data and sparse data, so chunks fall both ways.
    task automatic send_image();
        int         len;
        int         seg_left;
        fill_kind_t kind;
        byte_t      data;
        len      = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 160)
                                               : $urandom_range(1, 40);
        seg_left = 0;
        kind     = FILL_ZERO;
        for (int i = 0; i < len; i++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(1, 12);
                kind     = fill_kind_t'($urandom_range(0, 2));
            end
            seg_left--;
            case (kind)
                FILL_ZERO:  data = '0;
                FILL_DENSE: data = byte_t'($urandom_range(1, 255));
                default:    data = ($urandom_range(0, 5) == 0) ?
                                   byte_t'($urandom_range(0, 255)) : '0;
            endcase
            push_byte(data, i == len - 1);
        end
    endtask

    // Result side: stall at random, take each result and check it.
    initial
    begin
        int          stall;
        extent_rec_t got;
        wait (rst_n === 1'b1);
        forever begin
            stall = draw_wait(take_left, take_quiet);
            if (stall > 0) begin
                extent_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            extent_ch.ready <= 1'b1;
            do @(posedge clk); while (!extent_ch.valid);
            got.start      = extent_ch.extent_start;
            got.length     = extent_ch.extent_length;
            got.has_extent = extent_ch.extent_valid;
            got.image_end  = extent_ch.end_of_image;
            got.overflow   = extent_ch.size_overflow;
            ledger.check_result(got);
        end
    end

    // Main sequence: reset, directed images, random phases, verdict.
    initial
    begin
        int     phase;
        int     phase_start;
        field_t header_len;
        field_t chunk_len;

        // Drive every input to a known value before the first edge.
        rst_n              = 1'b0;
        image_ch.valid     = 1'b0;
        image_ch.data_byte = '0;
        image_ch.last_byte = 1'b0;
        extent_ch.ready    = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.reg_index   = REG_HEADER_BYTES;
        cfg_ch.write_data  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset sizes: the header is huge, so every image here is short and ends
        // inside it. Two single-byte images, all-ones and all-zero, then four bytes.
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h7F, 1'b1);
        drain_results();

        // Zero in both registers acts as one: every byte is its own chunk.
        // A zero byte closes the header extent, nonzero bytes open new ones,
        // and an image ending on zero chunks gives a bare end mark.
        set_sizes('0, '0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h55, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hAA, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);
        drain_results();

        // Short header and chunks of three: an all-zero chunk closes the
        // header extent, then a dirty final chunk opens and ends one.
        set_sizes(field_t'(2), field_t'(3));
        push_byte(8'h11, 1'b0);
        push_byte(8'h22, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h09, 1'b0);
        push_byte(8'h00, 1'b1);
        drain_results();

        // Random phases: fresh sizes between phases, each phase streaming
        // whole images; the drain before each write is the sender's hold-off.
        phase = 0;
        while (items_sent < TARGET_ITEMS) begin
            if (phase < 8) begin
                header_len = PRESET_HEADER[phase];
                chunk_len  = PRESET_CHUNK[phase];
            end
            else begin
                header_len = field_t'($urandom_range(0, 12));
                chunk_len  = field_t'($urandom_range(0, 10));
                if ($urandom_range(0, 5) == 0)
                    chunk_len = field_t'({$urandom, $urandom});
            end
            set_sizes(header_len, chunk_len);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS && items_sent < TARGET_ITEMS)
                send_image();
            drain_results();
            phase++;
        end

        // Set the sizes back to their reset values for one last image.
        set_sizes(HEADER_BYTES_RESET, CHUNK_BYTES_RESET);
        send_image();
        drain_results();

        if (ledger.failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Hard stop in case the block hangs on either channel.
    initial
    begin
        #(RUN_LIMIT);
        $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
rtl/nzef_pkg.sv
rtl/nzef_if.sv
rtl/nzef_tracker.sv
rtl/nzef_top.sv
bench/tb_top.sv
